// ===== design/glzw_pkg.sv =====
package glzw_pkg;

    localparam int unsigned CMD_W   = 2;
    localparam int unsigned STAT_W  = 3;
    localparam int unsigned ERR_W   = 3;
    localparam int unsigned PIX_W   = 8;
    localparam int unsigned BUF_W   = 20;
    localparam int unsigned BCNT_W  = 5;
    localparam int unsigned LIMIT_W = 24;
    localparam int unsigned ROOT_W  = 4;
    localparam int unsigned CFG_IDX_W  = 1;
    localparam int unsigned CFG_DATA_W = 24;

    localparam logic [CMD_W-1:0] CMD_START = 2'd0;
    localparam logic [CMD_W-1:0] CMD_FEED  = 2'd1;

    localparam logic [STAT_W-1:0] ST_PIXEL   = 3'd0;
    localparam logic [STAT_W-1:0] ST_ACCEPT  = 3'd1;
    localparam logic [STAT_W-1:0] ST_REFUSE  = 3'd2;
    localparam logic [STAT_W-1:0] ST_NEED    = 3'd3;
    localparam logic [STAT_W-1:0] ST_DONE    = 3'd4;
    localparam logic [STAT_W-1:0] ST_ERROR   = 3'd5;

    localparam logic [ERR_W-1:0] ERR_NONE      = 3'd0;
    localparam logic [ERR_W-1:0] ERR_FIRST     = 3'd1;
    localparam logic [ERR_W-1:0] ERR_RANGE     = 3'd2;
    localparam logic [ERR_W-1:0] ERR_LIMIT     = 3'd3;
    localparam logic [ERR_W-1:0] ERR_TRUNC     = 3'd4;
    localparam logic [ERR_W-1:0] ERR_NODATA    = 3'd5;

    localparam logic [CFG_IDX_W-1:0] REG_ROOT  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LIMIT = 1'd1;

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_RUN,
        PH_DONE,
        PH_ERR
    } t_phase;

    typedef enum logic [2:0] {
        S_WAIT,
        S_DECODE,
        S_WALK,
        S_CHECK,
        S_POP,
        S_OUT
    } t_state;

endpackage

// ===== design/glzw_ram.sv =====
module glzw_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

// ===== design/gif_lzw_decoder.sv =====
// GIF LZW decoder. Each input transaction is a command: start a stream, feed
// one data byte, or pull one output; every command yields exactly one result
// transaction (status, pixel index, error kind). The result of a start or a
// feed passes through S_DECODE and S_OUT before it is valid. A pull that pops
// a waiting pixel goes through S_DECODE, S_POP and S_OUT. A pull that decodes
// a new code walks its prefix chain through the dictionary memory for each
// pixel of the string, reading an entry in S_WALK and pushing it onto the
// stack in S_CHECK. When the code is the one being defined, its last pixel is
// already known. A first code after a clear is handled in S_DECODE, and each
// clear code swallowed on the way passes through S_DECODE once more. The
// dictionary (prefix and suffix) and the string stack are synchronous RAMs
// with a registered read port. The decoder handles one command at a time: the
// input is held off from acceptance until the result transaction has been
// taken. The dictionary needs no clearing pass, as entries are always written
// before use. Configuration writes are taken only between commands.
module gif_lzw_decoder #(
    parameter int unsigned MAX_CODE_WIDTH = 12,
    parameter int unsigned DICT_ENTRIES   = 4096
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // [1:0] cmd, [9:2] data_byte, [15:10] zero fill
    input  logic [15:0] s_axis_tdata,
    // final_byte
    input  logic        s_axis_tlast,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [2:0] status, [10:3] pixel_index, [13:11] error_kind, [15:14] zero fill
    output logic [15:0] m_axis_tdata,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [glzw_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [glzw_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import glzw_pkg::*;

    localparam int unsigned AW  = $clog2(DICT_ENTRIES);
    localparam int unsigned CW  = AW + 1;   // code counters that can hold DICT_ENTRIES
    localparam int unsigned WW  = $clog2(MAX_CODE_WIDTH + 1);

    // Configuration registers.
    logic [ROOT_W-1:0]  r_root_cfg;
    logic [LIMIT_W-1:0] r_limit;

    // Stream state.
    t_state             r_state, n_state;
    t_phase             r_phase, n_phase;
    logic [3:0]         r_root, n_root;
    logic [BUF_W-1:0]   r_buf, n_buf;
    logic [BCNT_W-1:0]  r_bcnt, n_bcnt;
    logic [WW-1:0]      r_width, n_width;
    logic [CW-1:0]      r_free, n_free;
    logic [AW-1:0]      r_prev, n_prev;
    logic [PIX_W-1:0]   r_pfirst, n_pfirst;
    logic               r_pvalid, n_pvalid;
    logic               r_seen, n_seen;
    logic [LIMIT_W-1:0] r_emit, n_emit;
    logic               r_ended, n_ended;
    logic [ERR_W-1:0]   r_err, n_err;
    logic [CW-1:0]      r_sp, n_sp;
    logic [AW-1:0]      r_code, n_code;
    logic [AW-1:0]      r_walk, n_walk;
    logic               r_kwk, n_kwk;

    // Command and result holding registers.
    logic [CMD_W-1:0]   r_cmd, n_cmd;
    logic [PIX_W-1:0]   r_byte, n_byte;
    logic               r_fin, n_fin;
    logic               r_ovalid, n_ovalid;
    logic [STAT_W-1:0]  r_ost, n_ost;
    logic [PIX_W-1:0]   r_opix, n_opix;
    logic [ERR_W-1:0]   r_oerr, n_oerr;

    // Memories.
    logic              dict_we;
    logic [AW-1:0]     dict_waddr, dict_raddr;
    logic [AW-1:0]     pre_wdata, pre_rdata;
    logic [PIX_W-1:0]  suf_wdata, suf_rdata;
    logic              stk_we;
    logic [AW-1:0]     stk_waddr, stk_raddr;
    logic [PIX_W-1:0]  stk_wdata, stk_rdata;

    glzw_ram #(.WIDTH(AW), .DEPTH(DICT_ENTRIES)) u_prefix (
        .i_clk(i_clk), .i_we(dict_we), .i_waddr(dict_waddr), .i_wdata(pre_wdata),
        .i_raddr(dict_raddr), .o_rdata(pre_rdata)
    );
    glzw_ram #(.WIDTH(PIX_W), .DEPTH(DICT_ENTRIES)) u_suffix (
        .i_clk(i_clk), .i_we(dict_we), .i_waddr(dict_waddr), .i_wdata(suf_wdata),
        .i_raddr(dict_raddr), .o_rdata(suf_rdata)
    );
    glzw_ram #(.WIDTH(PIX_W), .DEPTH(DICT_ENTRIES)) u_stack (
        .i_clk(i_clk), .i_we(stk_we), .i_waddr(stk_waddr), .i_wdata(stk_wdata),
        .i_raddr(stk_raddr), .o_rdata(stk_rdata)
    );

    // Combinational helpers.
    logic [AW:0]        clr_code;
    logic [AW-1:0]      cur_code;
    logic [CW-1:0]      width_top;
    logic [LIMIT_W-1:0] room;
    logic [3:0]         root_clip;

    assign clr_code   = (AW+1)'(1) << r_root;
    assign cur_code   = AW'(r_buf & ((BUF_W'(1) << r_width) - BUF_W'(1)));
    assign width_top  = CW'(1) << r_width;
    assign room       = r_limit - r_emit;
    assign root_clip  = (r_root_cfg < 4'd2) ? 4'd2 :
                        (r_root_cfg > 4'd8) ? 4'd8 : r_root_cfg;

    assign s_axis_tready = (r_state == S_WAIT) && !r_ovalid;
    assign o_cfg_ready   = (r_state == S_WAIT) && !r_ovalid;
    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = {2'b00, r_oerr, r_opix, r_ost};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_root_cfg <= 4'd8;
            r_limit    <= '1;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                REG_ROOT:  r_root_cfg <= i_cfg_data[ROOT_W-1:0];
                REG_LIMIT: r_limit    <= i_cfg_data[LIMIT_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_WAIT;
            r_phase  <= PH_IDLE;
            r_root   <= 4'd8;
            r_buf    <= '0;
            r_bcnt   <= '0;
            r_width  <= WW'(9);
            r_free   <= CW'(258);
            r_prev   <= '0;
            r_pfirst <= '0;
            r_pvalid <= 1'b0;
            r_seen   <= 1'b0;
            r_emit   <= '0;
            r_ended  <= 1'b0;
            r_err    <= ERR_NONE;
            r_sp     <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_phase  <= n_phase;
            r_root   <= n_root;
            r_buf    <= n_buf;
            r_bcnt   <= n_bcnt;
            r_width  <= n_width;
            r_free   <= n_free;
            r_prev   <= n_prev;
            r_pfirst <= n_pfirst;
            r_pvalid <= n_pvalid;
            r_seen   <= n_seen;
            r_emit   <= n_emit;
            r_ended  <= n_ended;
            r_err    <= n_err;
            r_sp     <= n_sp;
            r_ovalid <= n_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_code <= n_code;
        r_walk <= n_walk;
        r_kwk  <= n_kwk;
        r_cmd  <= n_cmd;
        r_byte <= n_byte;
        r_fin  <= n_fin;
        r_ost  <= n_ost;
        r_opix <= n_opix;
        r_oerr <= n_oerr;
    end

    always_comb begin
        n_state  = r_state;
        n_phase  = r_phase;
        n_root   = r_root;
        n_buf    = r_buf;
        n_bcnt   = r_bcnt;
        n_width  = r_width;
        n_free   = r_free;
        n_prev   = r_prev;
        n_pfirst = r_pfirst;
        n_pvalid = r_pvalid;
        n_seen   = r_seen;
        n_emit   = r_emit;
        n_ended  = r_ended;
        n_err    = r_err;
        n_sp     = r_sp;
        n_code   = r_code;
        n_walk   = r_walk;
        n_kwk    = r_kwk;
        n_cmd    = r_cmd;
        n_byte   = r_byte;
        n_fin    = r_fin;
        n_ovalid = r_ovalid;
        n_ost    = r_ost;
        n_opix   = r_opix;
        n_oerr   = r_oerr;
        dict_we    = 1'b0;
        dict_waddr = AW'(r_free);
        dict_raddr = r_walk;
        pre_wdata  = r_prev;
        suf_wdata  = r_pfirst;
        stk_we     = 1'b0;
        stk_waddr  = r_sp[AW-1:0];
        stk_wdata  = suf_rdata;
        stk_raddr  = AW'(r_sp - CW'(1));

        if (r_ovalid && m_axis_tready) begin
            n_ovalid = 1'b0;
        end

        case (r_state)
            S_WAIT: begin
                if (s_axis_tvalid && s_axis_tready) begin
                    n_cmd   = s_axis_tdata[1:0];
                    n_byte  = s_axis_tdata[9:2];
                    n_fin   = s_axis_tlast;
                    n_state = S_DECODE;
                end
            end
            S_DECODE: begin
                n_state = S_OUT;
                n_ost   = ST_ACCEPT;
                n_opix  = '0;
                n_oerr  = ERR_NONE;
                if (r_cmd == CMD_START) begin
                    n_root   = root_clip;
                    n_sp     = '0;
                    n_buf    = '0;
                    n_bcnt   = '0;
                    n_width  = WW'(root_clip + 4'd1);
                    n_free   = (CW'(1) << root_clip) + CW'(2);
                    n_prev   = '0;
                    n_pvalid = 1'b0;
                    n_pfirst = '0;
                    n_seen   = 1'b0;
                    n_emit   = '0;
                    n_ended  = 1'b0;
                    n_err    = ERR_NONE;
                    n_phase  = PH_RUN;
                end else if (r_phase == PH_DONE) begin
                    n_ost = ST_DONE;
                end else if (r_phase == PH_ERR) begin
                    n_ost  = ST_ERROR;
                    n_oerr = r_err;
                end else if (r_cmd == CMD_FEED) begin
                    if (r_phase != PH_RUN || r_ended || r_bcnt > BCNT_W'(12)) begin
                        n_ost = ST_REFUSE;
                    end else begin
                        n_buf   = r_buf | (BUF_W'(r_byte) << r_bcnt);
                        n_bcnt  = r_bcnt + BCNT_W'(8);
                        n_ended = r_fin;
                    end
                end else if (r_phase != PH_RUN) begin
                    n_ost = ST_NEED;
                end else if (r_sp != '0) begin
                    n_state = S_POP;
                end else if (r_bcnt < BCNT_W'(r_width)) begin
                    if (r_ended) begin
                        n_ost   = ST_ERROR;
                        n_oerr  = ERR_TRUNC;
                        n_err   = ERR_TRUNC;
                        n_phase = PH_ERR;
                    end else begin
                        n_ost = ST_NEED;
                    end
                end else begin
                    n_buf  = r_buf >> r_width;
                    n_bcnt = r_bcnt - BCNT_W'(r_width);
                    n_code = cur_code;
                    n_kwk  = 1'b0;
                    n_walk = cur_code;
                    if ({1'b0, cur_code} == clr_code) begin
                        n_width  = WW'(r_root + 4'd1);
                        n_free   = CW'(clr_code) + CW'(2);
                        n_pvalid = 1'b0;
                        n_state  = S_DECODE;
                    end else if ({1'b0, cur_code} == clr_code + (AW+1)'(1)) begin
                        if (!r_seen) begin
                            n_ost   = ST_ERROR;
                            n_oerr  = ERR_NODATA;
                            n_err   = ERR_NODATA;
                            n_phase = PH_ERR;
                        end else begin
                            n_ost   = ST_DONE;
                            n_phase = PH_DONE;
                        end
                    end else if (!r_pvalid) begin
                        if ({1'b0, cur_code} >= clr_code) begin
                            n_ost   = ST_ERROR;
                            n_oerr  = ERR_FIRST;
                            n_err   = ERR_FIRST;
                            n_phase = PH_ERR;
                        end else if (r_emit >= r_limit) begin
                            n_ost   = ST_ERROR;
                            n_oerr  = ERR_LIMIT;
                            n_err   = ERR_LIMIT;
                            n_phase = PH_ERR;
                        end else begin
                            n_emit   = r_emit + LIMIT_W'(1);
                            n_prev   = cur_code;
                            n_pfirst = PIX_W'(cur_code);
                            n_pvalid = 1'b1;
                            n_seen   = 1'b1;
                            n_ost    = ST_PIXEL;
                            n_opix   = PIX_W'(cur_code);
                        end
                    end else if (CW'(cur_code) < r_free) begin
                        n_state = S_WALK;
                    end else if (CW'(cur_code) == r_free) begin
                        // KwKwK: the string is the previous one plus its own first index.
                        stk_we    = 1'b1;
                        stk_waddr = '0;
                        stk_wdata = r_pfirst;
                        n_sp      = CW'(1);
                        n_kwk     = 1'b1;
                        n_walk    = r_prev;
                        n_state   = S_WALK;
                    end else begin
                        n_ost   = ST_ERROR;
                        n_oerr  = ERR_RANGE;
                        n_err   = ERR_RANGE;
                        n_phase = PH_ERR;
                    end
                end
            end
            S_WALK: begin
                // r_walk holds the current chain code; its entry is read now.
                if ({1'b0, r_walk} >= clr_code + (AW+1)'(2)
                        && r_sp < CW'(DICT_ENTRIES - 1)) begin
                    dict_raddr = r_walk;
                    n_state    = S_CHECK;
                end else begin
                    stk_we    = 1'b1;
                    stk_wdata = PIX_W'(r_walk);
                    n_pfirst  = PIX_W'(r_walk);
                    n_sp      = r_sp + CW'(1);
                    n_state   = S_POP;
                    if (LIMIT_W'(r_sp + CW'(1)) > room
                            || (CW'(LIMIT_W'(r_sp + CW'(1))) != r_sp + CW'(1))) begin
                        n_sp    = '0;
                        n_ost   = ST_ERROR;
                        n_opix  = '0;
                        n_oerr  = ERR_LIMIT;
                        n_err   = ERR_LIMIT;
                        n_phase = PH_ERR;
                        n_state = S_OUT;
                    end else begin
                        n_emit = r_emit + LIMIT_W'(r_sp + CW'(1));
                        n_prev = r_code;
                        n_seen = 1'b1;
                        if (r_free < CW'(DICT_ENTRIES)) begin
                            dict_we   = 1'b1;
                            suf_wdata = PIX_W'(r_walk);
                            n_free    = r_free + CW'(1);
                            if (r_free + CW'(1) == width_top
                                    && r_width < WW'(MAX_CODE_WIDTH)) begin
                                n_width = r_width + WW'(1);
                            end
                        end
                    end
                end
            end
            S_CHECK: begin
                stk_we  = 1'b1;
                stk_wdata = suf_rdata;
                n_sp    = r_sp + CW'(1);
                n_walk  = pre_rdata;
                n_state = S_WALK;
            end
            S_POP: begin
                // Read the top of the stack; data appears next cycle.
                stk_raddr = AW'(r_sp - CW'(1));
                n_sp      = r_sp - CW'(1);
                n_state   = S_OUT;
                n_ost     = ST_PIXEL;
                n_oerr    = ERR_NONE;
                n_kwk     = 1'b1;
            end
            S_OUT: begin
                if (r_kwk && r_ost == ST_PIXEL) begin
                    n_opix = stk_rdata;
                end
                n_kwk    = 1'b0;
                n_ovalid = 1'b1;
                n_state  = S_WAIT;
            end
            default: n_state = S_WAIT;
        endcase
    end

    // Only one command is in flight: no input while a result is pending.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ovalid |-> !s_axis_tready)
        else $error("input accepted while a result waits");
    // The code width never exceeds its limit.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_width <= WW'(MAX_CODE_WIDTH))
        else $error("code width overflow");
    // The bit buffer never holds more than its width.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_bcnt <= BCNT_W'(BUF_W))
        else $error("bit buffer overflow");
    // An error result always carries a kind.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ovalid && r_ost == ST_ERROR) |-> r_oerr != ERR_NONE)
        else $error("error without kind");
endmodule

// ===== bench/gif_lzw_checker.sv =====
`timescale 1ns / 100ps

// Watches the command, result and register channels of the decoder. It keeps its
// own copy of the decoder state and works out the result of every accepted
// command. Each result is then compared with the oldest outstanding one.
module gif_lzw_checker (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cmd_valid,
    input  logic                            i_cmd_ready,
    input  logic [15:0]                     i_cmd_data,
    input  logic                            i_cmd_last,
    input  logic                            i_res_valid,
    input  logic                            i_res_ready,
    input  logic [15:0]                     i_res_data,
    input  logic                            i_cfg_valid,
    input  logic                            i_cfg_ready,
    input  logic [glzw_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [glzw_pkg::CFG_DATA_W-1:0] i_cfg_data,
    output int                              o_mismatches,
    output int                              o_pending
);
    import glzw_pkg::*;

    typedef struct packed {
        logic [STAT_W-1:0] status;
        logic [PIX_W-1:0]  pixel;
        logic [ERR_W-1:0]  kind;
    } t_result;

    t_result     pending_results[$];
    int          mismatches = 0;

    logic [11:0] dict_prefix [4096];
    logic [7:0]  dict_suffix [4096];
    logic [7:0]  pixel_stack [4096];
    int unsigned stack_depth, bit_store, bits_held, code_bits, free_code;
    int unsigned last_code, last_first, pixels_out, root_bits, latched_error;
    int unsigned root_reg, limit_reg;
    bit          have_last, data_seen, input_closed;
    t_phase      phase;

    assign o_mismatches = mismatches;
    assign o_pending    = pending_results.size();

    initial begin
        for (int i = 0; i < 4096; i++) begin
            dict_prefix[i] = '0;
            dict_suffix[i] = '0;
            pixel_stack[i] = '0;
        end
    end

    function automatic t_result pack_result(int unsigned st, int unsigned px, int unsigned ek);
        t_result r;
        r.status = st[STAT_W-1:0];
        r.pixel  = px[PIX_W-1:0];
        r.kind   = ek[ERR_W-1:0];
        return r;
    endfunction

    function automatic void open_stream();
        int unsigned r;
        r = root_reg;
        if (r < 2) r = 2;
        if (r > 8) r = 8;
        root_bits     = r;
        stack_depth   = 0;
        bit_store     = 0;
        bits_held     = 0;
        code_bits     = r + 1;
        free_code     = (1 << r) + 2;
        last_code     = 0;
        have_last     = 0;
        last_first    = 0;
        data_seen     = 0;
        pixels_out    = 0;
        input_closed  = 0;
        latched_error = ERR_NONE;
    endfunction

    function automatic t_result latch_error(logic [ERR_W-1:0] kind);
        phase         = PH_ERR;
        latched_error = kind;
        stack_depth   = 0;
        return pack_result(ST_ERROR, 0, kind);
    endfunction

    function automatic t_result pop_pixel();
        stack_depth--;
        return pack_result(ST_PIXEL, pixel_stack[stack_depth & 4095], ERR_NONE);
    endfunction

    // One pull: pop a waiting pixel, or cut codes until one yields an answer.
    function automatic t_result decode_pull();
        int unsigned clr_code, code, c, first;
        clr_code = 1 << root_bits;
        while (1) begin
            if (stack_depth > 0) return pop_pixel();
            if (bits_held < code_bits) begin
                if (input_closed) return latch_error(ERR_TRUNC);
                return pack_result(ST_NEED, 0, ERR_NONE);
            end
            code = bit_store & ((1 << code_bits) - 1);
            bit_store = bit_store >> code_bits;
            bits_held -= code_bits;
            if (code == clr_code) begin
                code_bits = root_bits + 1;
                free_code = clr_code + 2;
                have_last = 0;
                continue;
            end
            if (code == clr_code + 1) begin
                if (!data_seen) return latch_error(ERR_NODATA);
                phase = PH_DONE;
                return pack_result(ST_DONE, 0, ERR_NONE);
            end
            if (!have_last) begin
                if (code >= clr_code) return latch_error(ERR_FIRST);
                if (pixels_out >= limit_reg) return latch_error(ERR_LIMIT);
                pixels_out++;
                last_code  = code;
                last_first = code;
                have_last  = 1;
                data_seen  = 1;
                return pack_result(ST_PIXEL, code, ERR_NONE);
            end
            if (code < free_code) begin
                c = code;
            end else if (code == free_code) begin
                // The code being defined right now: previous string plus its own head.
                pixel_stack[0] = last_first[7:0];
                stack_depth = 1;
                c = last_code;
            end else begin
                return latch_error(ERR_RANGE);
            end
            while (c >= clr_code + 2 && stack_depth < 4095) begin
                pixel_stack[stack_depth] = dict_suffix[c & 4095];
                stack_depth++;
                c = dict_prefix[c & 4095];
            end
            c &= 255;
            pixel_stack[stack_depth & 4095] = c[7:0];
            stack_depth++;
            first = c;
            // The whole string must fit under the limit before any of it leaves.
            if (stack_depth > limit_reg - pixels_out) return latch_error(ERR_LIMIT);
            pixels_out += stack_depth;
            if (free_code < 4096) begin
                dict_prefix[free_code] = last_code[11:0];
                dict_suffix[free_code] = first[7:0];
                free_code++;
                if (free_code == (1 << code_bits) && code_bits < 12) code_bits++;
            end
            last_code  = code;
            last_first = first;
            data_seen  = 1;
            return pop_pixel();
        end
        return pack_result(ST_NEED, 0, ERR_NONE);
    endfunction

    function automatic t_result predict_command(logic [1:0] cmd, logic [7:0] data, logic fin);
        if (cmd == CMD_START) begin
            open_stream();
            phase = PH_RUN;
            return pack_result(ST_ACCEPT, 0, ERR_NONE);
        end
        if (phase == PH_DONE) return pack_result(ST_DONE, 0, ERR_NONE);
        if (phase == PH_ERR) return pack_result(ST_ERROR, 0, latched_error);
        if (cmd == CMD_FEED) begin
            if (phase != PH_RUN || input_closed || bits_held > 12)
                return pack_result(ST_REFUSE, 0, ERR_NONE);
            bit_store |= int'(data) << bits_held;
            bits_held += 8;
            if (fin) input_closed = 1;
            return pack_result(ST_ACCEPT, 0, ERR_NONE);
        end
        if (phase != PH_RUN) return pack_result(ST_NEED, 0, ERR_NONE);
        return decode_pull();
    endfunction

    always @(posedge i_clk) begin
        t_result seen, want;
        if (!i_rst_n) begin
            root_reg  = 8;
            limit_reg = 24'hFFFFFF;
            open_stream();
            phase = PH_IDLE;
            pending_results.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                if (i_cfg_index == REG_ROOT) root_reg = i_cfg_data[ROOT_W-1:0];
                else if (i_cfg_index == REG_LIMIT) limit_reg = i_cfg_data[LIMIT_W-1:0];
            end
            if (i_cmd_valid && i_cmd_ready)
                pending_results = {pending_results,
                                   predict_command(i_cmd_data[1:0], i_cmd_data[9:2],
                                                   i_cmd_last)};
            if (i_res_valid && i_res_ready) begin
                seen = {i_res_data[2:0], i_res_data[10:3], i_res_data[13:11]};
                if (pending_results.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("%0t: result with nothing outstanding: status %0d pixel %0d kind %0d",
                                 $realtime, seen.status, seen.pixel, seen.kind);
                end else begin
                    want = pending_results.pop_front();
                    if (seen.status !== want.status || seen.pixel !== want.pixel ||
                        seen.kind !== want.kind) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("%0t: expected status %0d pixel %0d kind %0d, got %0d %0d %0d",
                                     $realtime, want.status, want.pixel, want.kind,
                                     seen.status, seen.pixel, seen.kind);
                    end
                end
            end
        end
    end

endmodule

// ===== bench/tb_gif_lzw_decoder.sv =====
`timescale 1ns / 100ps

// Top of the decoder bench. It builds LZW code streams, feeds them byte by byte
// and pulls results until the decoder asks for more data, finishes or fails.
// The checker beside the decoder does all prediction and comparison; this
// module only makes stimulus and gives the verdict.
module tb_gif_lzw_decoder;
    import glzw_pkg::*;

    localparam logic [CMD_W-1:0] CMD_PULL     = 2'd2;
    // Any code other than start and feed is decoded as a pull, so this code also pulls.
    localparam logic [CMD_W-1:0] CMD_RESERVED = 2'd3;
    localparam int               CYCLE_LIMIT  = 2000000;

    typedef enum {
        SK_GOOD,
        SK_BAD_FIRST,
        SK_RANGE,
        SK_NO_DATA,
        SK_TRUNCATED,
        SK_FULL_DICT
    } t_stream_kind;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [15:0]           s_axis_tdata = '0;
    logic                  s_axis_tlast = 1'b0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [15:0]           m_axis_tdata;
    logic                  i_cfg_valid = 1'b0;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;

    int                    mismatches, outstanding;
    int                    sent_count = 0;
    int                    answered_count = 0;
    logic [STAT_W-1:0]     last_status = ST_NEED;
    int                    send_idle_pct = 0;
    int                    recv_stall_pct = 0;
    bit                    recv_hold = 0;
    int                    cycle_count = 0;

    // Bytes of the stream under construction and the bit packer behind them.
    logic [7:0]            stream_bytes[$];
    int unsigned           pack_acc, pack_bits;

    gif_lzw_decoder DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    gif_lzw_checker checker_inst (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd_valid  (s_axis_tvalid),
        .i_cmd_ready  (s_axis_tready),
        .i_cmd_data   (s_axis_tdata),
        .i_cmd_last   (s_axis_tlast),
        .i_res_valid  (m_axis_tvalid),
        .i_res_ready  (m_axis_tready),
        .i_res_data   (m_axis_tdata),
        .i_cfg_valid  (i_cfg_valid),
        .i_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .o_mismatches (mismatches),
        .o_pending    (outstanding)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // The receiver stalls at random, or holds off entirely while a long
    // back-pressure stretch is running.
    always @(posedge i_clk) begin
        m_axis_tready <= !recv_hold && ($urandom_range(99) >= recv_stall_pct);
    end

    // The sender steers its streams by the status of the latest result.
    always @(posedge i_clk) begin
        if (m_axis_tvalid && m_axis_tready) begin
            answered_count <= answered_count + 1;
            last_status    <= m_axis_tdata[2:0];
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("gif_lzw_decoder regression: fail");
            $finish;
        end
    end

    // Offers one command and returns at the edge where the transaction is taken.
    // The valid stays high afterwards, so back-to-back commands need no gap.
    task automatic send(input logic [1:0] cmd, input logic [7:0] data, input logic fin);
        if ($urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < send_idle_pct);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {6'b0, data, cmd};
        s_axis_tlast  <= fin;
        do @(posedge i_clk); while (!s_axis_tready);
        sent_count++;
    endtask

    // Drops the valid and waits until every command sent has been answered.
    task automatic settle();
        s_axis_tvalid <= 1'b0;
        do @(posedge i_clk); while (answered_count != sent_count);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] index, input int unsigned value);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= index;
        i_cfg_data  <= value[CFG_DATA_W-1:0];
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic put_code(input int unsigned code, input int unsigned width);
        pack_acc |= code << pack_bits;
        pack_bits += width;
        while (pack_bits >= 8) begin
            stream_bytes = {stream_bytes, pack_acc[7:0]};
            pack_acc = pack_acc >> 8;
            pack_bits -= 8;
        end
    endtask

    // Builds a code stream that tracks the decoder's dictionary growth and code
    // width, so that back-references stay legal unless a fault is wanted.
    task automatic build_stream(input t_stream_kind kind, input int unsigned root,
                                input int count);
        int unsigned clr_code, width, free_slot, code, pick;
        bit          started;
        stream_bytes.delete();
        pack_acc   = 0;
        pack_bits  = 0;
        clr_code   = 1 << root;
        width      = root + 1;
        free_slot  = clr_code + 2;
        started    = 0;
        if (kind == SK_NO_DATA) count = 0;
        if ($urandom_range(1)) put_code(clr_code, width);
        for (int i = 0; i < count; i++) begin
            if (started && kind != SK_FULL_DICT && $urandom_range(29) == 0) begin
                put_code(clr_code, width);
                width     = root + 1;
                free_slot = clr_code + 2;
                started   = 0;
                continue;
            end
            if (!started) begin
                if (kind == SK_BAD_FIRST) begin
                    put_code($urandom_range(clr_code + 2, 2 * clr_code - 1), width);
                    break;
                end
                put_code($urandom_range(clr_code - 1), width);
                started = 1;
                continue;
            end
            pick = $urandom_range(99);
            if (kind == SK_FULL_DICT ? pick < 90 : pick < 50)
                code = $urandom_range(clr_code - 1);
            else if (pick < 85 && free_slot < 4096)
                code = $urandom_range(clr_code + 2, free_slot);
            else if (free_slot < 4096)
                code = free_slot;
            else
                code = $urandom_range(clr_code + 2, 4095);
            if (kind == SK_RANGE && i == count - 1 && (1 << width) - 1 > free_slot) begin
                put_code((1 << width) - 1, width);
                break;
            end
            put_code(code, width);
            if (free_slot < 4096) begin
                free_slot++;
                if (free_slot == (1 << width) && width < 12) width++;
            end
        end
        if (kind != SK_TRUNCATED) put_code(clr_code + 1, width);
        if (pack_bits > 0) stream_bytes = {stream_bytes, pack_acc[7:0]};
        if (stream_bytes.size() == 0) stream_bytes = {stream_bytes, 8'($urandom_range(255))};
    endtask

    // Starts a stream, then feeds each byte and pulls until the decoder needs
    // more data, reports done or fails.
    task automatic run_stream(input t_stream_kind kind, input int unsigned root_reg,
                              input int count, input int unsigned limit);
        int unsigned root;
        int          pulls;
        bit          stopped;
        write_reg(REG_ROOT, root_reg);
        write_reg(REG_LIMIT, limit);
        root = root_reg < 2 ? 2 : (root_reg > 8 ? 8 : root_reg);
        build_stream(kind, root, count);
        send(CMD_START, 8'($urandom_range(255)), 1'($urandom_range(1)));
        settle();
        stopped = 0;
        for (int i = 0; i < stream_bytes.size() && !stopped; i++) begin
            send(CMD_FEED, stream_bytes[i], i == stream_bytes.size() - 1);
            settle();
            if (last_status == ST_DONE || last_status == ST_ERROR) stopped = 1;
            pulls = 0;
            while (!stopped && pulls < 6000) begin
                send($urandom_range(9) == 0 ? CMD_RESERVED : CMD_PULL,
                     8'($urandom_range(255)), 1'($urandom_range(1)));
                settle();
                pulls++;
                if (last_status == ST_DONE || last_status == ST_ERROR) stopped = 1;
                else if (last_status == ST_NEED) break;
            end
        end
        // A finished or failed stream keeps answering with its final state.
        if ($urandom_range(3) == 0) begin
            send(CMD_FEED, 8'($urandom_range(255)), 1'($urandom_range(1)));
            send(CMD_PULL, 8'h00, 1'b0);
            settle();
        end
    endtask

    // Commands of any kind sent back to back without waiting for answers.
    task automatic send_noise(input int count);
        logic [1:0] cmd;
        for (int i = 0; i < count; i++) begin
            cmd = $urandom_range(7) == 0 ? CMD_START : CMD_W'($urandom_range(1, 3));
            send(cmd, 8'($urandom_range(255)), 1'($urandom_range(1)));
        end
        settle();
    endtask

    initial begin
        int phase_end;
        t_stream_kind kind;
        int unsigned pick;

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Commands before any start: a pull asks for data, a feed is refused.
        send(CMD_PULL, 8'hFF, 1'b1);
        send(CMD_FEED, 8'hA5, 1'b1);
        send(CMD_RESERVED, 8'h5A, 1'b0);
        settle();

        // Plain streams and every fault, with the root width at and beyond its range.
        run_stream(SK_GOOD, 8, 12, 24'hFFFFFF);
        run_stream(SK_GOOD, 0, 10, 24'hFFFFFF);
        run_stream(SK_GOOD, 15, 10, 24'hFFFFFF);
        run_stream(SK_BAD_FIRST, 4, 5, 24'hFFFFFF);
        run_stream(SK_RANGE, 3, 8, 24'hFFFFFF);
        run_stream(SK_NO_DATA, 2, 0, 24'hFFFFFF);
        run_stream(SK_TRUNCATED, 5, 6, 24'hFFFFFF);
        run_stream(SK_GOOD, 6, 10, 0);
        run_stream(SK_GOOD, 8, 20, 5);

        // Buffer overrun, then a feed after the final byte and a truncated end.
        write_reg(REG_ROOT, 8);
        send(CMD_START, 8'h00, 1'b0);
        send(CMD_FEED, 8'hFF, 1'b0);
        send(CMD_FEED, 8'h00, 1'b0);
        send(CMD_FEED, 8'h01, 1'b1);
        send(CMD_START, 8'h00, 1'b0);
        send(CMD_FEED, 8'h07, 1'b1);
        send(CMD_FEED, 8'h07, 1'b0);
        send(CMD_PULL, 8'h00, 1'b0);
        send(CMD_PULL, 8'h00, 1'b0);
        settle();

        // The receiver holds off while commands keep coming, so the decoder fills up.
        write_reg(REG_ROOT, 8);
        fork
            begin
                recv_hold = 1;
                repeat (400) @(posedge i_clk);
                recv_hold = 0;
            end
        join_none
        send(CMD_START, 8'h00, 1'b0);
        send_noise(40);

        for (int p = 0; p < 4; p++) begin
            case (p)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 88; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 88; end
                default: begin send_idle_pct = 12; recv_stall_pct = 12; end
            endcase
            phase_end = sent_count + 130;
            while (sent_count < phase_end) begin
                pick = $urandom_range(99);
                if (pick < 70)      kind = SK_GOOD;
                else if (pick < 76) kind = SK_BAD_FIRST;
                else if (pick < 83) kind = SK_RANGE;
                else if (pick < 87) kind = SK_NO_DATA;
                else                kind = SK_TRUNCATED;
                run_stream(kind,
                           $urandom_range(9) == 0 ? $urandom_range(15) : $urandom_range(2, 8),
                           $urandom_range(2, 25),
                           $urandom_range(9) == 0 ? $urandom_range(30) : 24'hFFFFFF);
                if ($urandom_range(5) == 0) send_noise(8);
            end
        end

        settle();
        repeat (100) @(posedge i_clk);
        if (mismatches == 0 && outstanding == 0) begin
            $display("gif_lzw_decoder regression: pass");
        end else begin
            $display("gif_lzw_decoder regression: fail");
        end
        $finish;
    end

endmodule
